// ===== sv/cpu_alu_pkg.sv =====
// cpu_alu_pkg: command codes, flag and transaction types for the 8-bit alu
// used by cpu_8bit_alu_with_flags; depends on nothing else

package cpu_alu_pkg;

   // operation codes carried in the command field
   typedef enum logic [4:0] {
      CMD_ADD  = 5'd0,
      CMD_ADC  = 5'd1,
      CMD_SUB  = 5'd2,
      CMD_SBC  = 5'd3,
      CMD_AND  = 5'd4,
      CMD_XOR  = 5'd5,
      CMD_OR   = 5'd6,
      CMD_CP   = 5'd7,
      CMD_INC  = 5'd8,
      CMD_DEC  = 5'd9,
      CMD_RLC  = 5'd10,
      CMD_RRC  = 5'd11,
      CMD_RL   = 5'd12,
      CMD_RR   = 5'd13,
      CMD_SLA  = 5'd14,
      CMD_SRA  = 5'd15,
      CMD_SWAP = 5'd16,
      CMD_SRL  = 5'd17,
      CMD_BIT  = 5'd18,
      CMD_RES  = 5'd19,
      CMD_SET  = 5'd20,
      CMD_DAA  = 5'd21
   } cmd_type;

   // decimal adjust constants
   localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
   localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
   localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

   // z, n, h, c flag register
   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   // request transaction
   typedef struct packed {
      cmd_type    command;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic [2:0] bit_index;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [7:0] result_value;
      logic       write_back;
      logic       zero_flag;
      logic       subtract_flag;
      logic       half_carry_flag;
      logic       carry_flag;
   } rsp_type;

endpackage

// ===== sv/cpu_8bit_alu_with_flags.sv =====
// cpu_8bit_alu_with_flags: 8-bit alu with z/n/h/c flag register
// stages: input register, result register; flag register feeds back through one alu pass
// throughput: one transaction per cycle while no response is held by rsp_stall
// reset: synchronous active high, clears both valid bits and the flag register
// depends on cpu_alu_pkg

module cpu_8bit_alu_with_flags (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cpu_alu_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cpu_alu_pkg::rsp_type rsp_payload
);

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   cpu_alu_pkg::req_type  s1_ff;
   // result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   cpu_alu_pkg::rsp_type  rsp_ff, rsp_in;
   // flag register
   cpu_alu_pkg::flags_type flags_ff, flags_in;

   logic out_free;
   logic s1_advance;
   logic req_take;

   // handshake control
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_advance  = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !out_free;
   assign req_take    = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && rsp_stall);

   // alu datapath
   logic [7:0] a, b, r;
   logic [8:0] sum9, dif9;
   logic [4:0] sum5, dif5;
   logic [7:0] daa_t;
   logic       cin, wb, shift_out;
   cpu_alu_pkg::flags_type nf;

   always_comb begin
      a    = s1_ff.operand_a;
      b    = s1_ff.operand_b;
      cin  = ((s1_ff.command == cpu_alu_pkg::CMD_ADC) ||
              (s1_ff.command == cpu_alu_pkg::CMD_SBC)) ? flags_ff.c : 1'b0;
      sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
      dif9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
      sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
      dif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
      r    = a;
      wb   = 1'b1;
      nf   = flags_ff;
      shift_out = 1'b0;
      daa_t = a;
      case (s1_ff.command)
         cpu_alu_pkg::CMD_ADD, cpu_alu_pkg::CMD_ADC: begin
            r = sum9[7:0];
            nf.z = (r == 8'd0); nf.n = 1'b0; nf.h = sum5[4]; nf.c = sum9[8];
         end
         cpu_alu_pkg::CMD_SUB, cpu_alu_pkg::CMD_SBC, cpu_alu_pkg::CMD_CP: begin
            r = dif9[7:0];
            nf.z = (r == 8'd0); nf.n = 1'b1; nf.h = dif5[4]; nf.c = dif9[8];
            wb = (s1_ff.command != cpu_alu_pkg::CMD_CP);
         end
         cpu_alu_pkg::CMD_AND: begin
            r = a & b;
            nf.z = (r == 8'd0); nf.n = 1'b0; nf.h = 1'b1; nf.c = 1'b0;
         end
         cpu_alu_pkg::CMD_XOR: begin
            r = a ^ b;
            nf.z = (r == 8'd0); nf.n = 1'b0; nf.h = 1'b0; nf.c = 1'b0;
         end
         cpu_alu_pkg::CMD_OR: begin
            r = a | b;
            nf.z = (r == 8'd0); nf.n = 1'b0; nf.h = 1'b0; nf.c = 1'b0;
         end
         cpu_alu_pkg::CMD_INC: begin
            r = a + 8'd1;
            nf.z = (r == 8'd0); nf.n = 1'b0; nf.h = (a[3:0] == 4'hF);
         end
         cpu_alu_pkg::CMD_DEC: begin
            r = a - 8'd1;
            nf.z = (r == 8'd0); nf.n = 1'b1; nf.h = (a[3:0] == 4'h0);
         end
         cpu_alu_pkg::CMD_RLC, cpu_alu_pkg::CMD_RRC, cpu_alu_pkg::CMD_RL,
         cpu_alu_pkg::CMD_RR, cpu_alu_pkg::CMD_SLA, cpu_alu_pkg::CMD_SRA,
         cpu_alu_pkg::CMD_SRL: begin
            // left moves shift out bit 7, right moves bit 0
            if ((s1_ff.command == cpu_alu_pkg::CMD_RLC) ||
                (s1_ff.command == cpu_alu_pkg::CMD_RL) ||
                (s1_ff.command == cpu_alu_pkg::CMD_SLA)) begin
               shift_out = a[7];
            end else begin
               shift_out = a[0];
            end
            if (s1_ff.command == cpu_alu_pkg::CMD_RLC) begin
               r = {a[6:0], a[7]};
            end else if (s1_ff.command == cpu_alu_pkg::CMD_RRC) begin
               r = {a[0], a[7:1]};
            end else if (s1_ff.command == cpu_alu_pkg::CMD_RL) begin
               r = {a[6:0], flags_ff.c};
            end else if (s1_ff.command == cpu_alu_pkg::CMD_RR) begin
               r = {flags_ff.c, a[7:1]};
            end else if (s1_ff.command == cpu_alu_pkg::CMD_SLA) begin
               r = {a[6:0], 1'b0};
            end else if (s1_ff.command == cpu_alu_pkg::CMD_SRA) begin
               r = {a[7], a[7:1]};
            end else begin
               r = {1'b0, a[7:1]};
            end
            nf.z = (r == 8'd0); nf.n = 1'b0; nf.h = 1'b0; nf.c = shift_out;
         end
         cpu_alu_pkg::CMD_SWAP: begin
            r = {a[3:0], a[7:4]};
            nf.z = (r == 8'd0); nf.n = 1'b0; nf.h = 1'b0; nf.c = 1'b0;
         end
         cpu_alu_pkg::CMD_BIT: begin
            wb = 1'b0;
            nf.z = !a[s1_ff.bit_index]; nf.n = 1'b0; nf.h = 1'b1;
         end
         cpu_alu_pkg::CMD_RES: begin
            r = a & ~(8'd1 << s1_ff.bit_index);
         end
         cpu_alu_pkg::CMD_SET: begin
            r = a | (8'd1 << s1_ff.bit_index);
         end
         cpu_alu_pkg::CMD_DAA: begin
            // high correction first; it leaves the low nibble untouched
            if (!flags_ff.n) begin
               if (flags_ff.c || (a > cpu_alu_pkg::DAA_HI_LIMIT)) begin
                  daa_t = a + cpu_alu_pkg::DAA_HI_ADJ;
                  nf.c  = 1'b1;
               end
               if (flags_ff.h || (a[3:0] > cpu_alu_pkg::DAA_LO_LIMIT)) begin
                  r = daa_t + cpu_alu_pkg::DAA_LO_ADJ;
               end else begin
                  r = daa_t;
               end
            end else begin
               if (flags_ff.c) begin
                  daa_t = a - cpu_alu_pkg::DAA_HI_ADJ;
               end
               if (flags_ff.h) begin
                  r = daa_t - cpu_alu_pkg::DAA_LO_ADJ;
               end else begin
                  r = daa_t;
               end
            end
            nf.z = (r == 8'd0); nf.h = 1'b0;
         end
         default: begin
            wb = 1'b0;
         end
      endcase
   end

   // response and flag next values
   always_comb begin
      rsp_in.result_value    = r;
      rsp_in.write_back      = wb;
      rsp_in.zero_flag       = nf.z;
      rsp_in.subtract_flag   = nf.n;
      rsp_in.half_carry_flag = nf.h;
      rsp_in.carry_flag      = nf.c;
      flags_in = s1_advance ? nf : flags_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= req_payload;
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // flags shown with a response match the flag register
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (rsp_ff.zero_flag == flags_ff.z) && (rsp_ff.subtract_flag == flags_ff.n)
                     && (rsp_ff.half_carry_flag == flags_ff.h)
                     && (rsp_ff.carry_flag == flags_ff.c))
      else $error("response flags differ from flag register");

   // res and set leave every flag alone
   a_res_set_flags: assert property (@(posedge clock) disable iff (reset)
      s1_advance && ((s1_ff.command == cpu_alu_pkg::CMD_RES) ||
                     (s1_ff.command == cpu_alu_pkg::CMD_SET)) |=> flags_ff == $past(flags_ff))
      else $error("res or set changed flags");

   // compare and bit test never write back
   a_no_write: assert property (@(posedge clock) disable iff (reset)
      s1_advance && ((s1_ff.command == cpu_alu_pkg::CMD_CP) ||
                     (s1_ff.command == cpu_alu_pkg::CMD_BIT)) |=> !rsp_ff.write_back)
      else $error("cp or bit marked for write back");

   // flags only move when a transaction leaves the input stage
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> flags_ff == $past(flags_ff))
      else $error("flag register changed without a transaction");

endmodule
